### design/ucsc_pkg.sv
// Shared types, constants and helpers for the UDP client session counter table.
package ucsc_pkg;

  localparam int unsigned TableEntries = 16;
  localparam logic [15:0] ListenPortReset = 16'd9090;
  localparam logic [7:0]  ProtoUdp = 8'd17;

  typedef enum logic {
    OP_DATAGRAM = 1'b0,
    OP_REMOVE   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_DROPPED = 3'd0,
    ST_NEW     = 3'd1,
    ST_KNOWN   = 3'd2,
    ST_REMOVED = 3'd3,
    ST_MISS    = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [7:0]  ip_protocol;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] packet_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] tally;
  } entry_t;

  typedef struct packed {
    logic remove;
    logic insert;
    logic bump;
  } cell_ctl_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

### design/ucsc_cell.sv
// One session slot: key compare, tally update and shift-down on removal.
module ucsc_cell #(
  parameter int unsigned CntW  = 5,
  parameter int unsigned INDEX = 0
) (
  input  logic              clk_i,
  input  ucsc_pkg::cell_ctl_t ctl_i,
  input  logic [31:0]       key_addr_i,
  input  logic [15:0]       key_port_i,
  input  logic [CntW-1:0]   occ_i,
  input  ucsc_pkg::entry_t  nbr_i,
  input  logic              seen_i,
  input  logic [31:0]       tally_i,
  output ucsc_pkg::entry_t  entry_o,
  output logic              seen_o,
  output logic [31:0]       tally_o
);

  ucsc_pkg::entry_t entry_q, entry_d;
  logic live, hit, at_end;

  assign live    = CntW'(INDEX) < occ_i;
  assign at_end  = CntW'(INDEX) == occ_i;
  assign hit     = live && (entry_q.addr == key_addr_i) && (entry_q.port == key_port_i);
  assign seen_o  = seen_i | hit;
  assign tally_o = tally_i | (hit ? entry_q.tally : 32'd0);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.remove && seen_o) begin
      entry_d = nbr_i;
    end else if (ctl_i.insert && at_end) begin
      entry_d.addr  = key_addr_i;
      entry_d.port  = key_port_i;
      entry_d.tally = 32'd1;
    end else if (ctl_i.bump && hit) begin
      entry_d.tally = ucsc_pkg::sat_inc(entry_q.tally);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### design/udp_client_session_counter_table_top.sv
// Top level of the UDP client session counter table: control, filter and cell row.
//   channel | direction | handshake             | beat
//   in      | input     | in_valid_i/in_stall_o   | ucsc_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | ucsc_pkg::out_item_t
//   cfg     | input     | cfg_valid_i/cfg_ready_o | listen port, 16 bit
// Each beat is first captured, then compared against every cell of the row
// at once, and the table update is committed.
// A remove shifts every slot above the match down by one as the update commits.
// Reset empties the table and restores the listen port; no clearing pass.
// A stalled output holds the commit cycle until the result register frees.
module udp_client_session_counter_table_top #(
  parameter int unsigned TABLE_ENTRIES = ucsc_pkg::TableEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ucsc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ucsc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_e;

  state_e              state_q, state_d;
  ucsc_pkg::in_item_t  item_q;
  logic [15:0]         listen_q;
  logic [CntW-1:0]     occ_q, occ_d;
  logic                out_valid_q, out_valid_d;
  ucsc_pkg::out_item_t out_q, res;
  ucsc_pkg::cell_ctl_t ctl;
  logic                commit, pass, found, full;
  logic [31:0]         found_tally;

  ucsc_pkg::entry_t    ent  [TABLE_ENTRIES];
  logic                seen [TABLE_ENTRIES+1];
  logic [31:0]         tally[TABLE_ENTRIES+1];

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign seen[0]  = 1'b0;
  assign tally[0] = 32'd0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ucsc_pkg::entry_t nbr;
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    ucsc_cell #(.CntW(CntW), .INDEX(i)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_addr_i (item_q.src_addr),
      .key_port_i (item_q.src_port),
      .occ_i      (occ_q),
      .nbr_i      (nbr),
      .seen_i     (seen[i]),
      .tally_i    (tally[i]),
      .entry_o    (ent[i]),
      .seen_o     (seen[i+1]),
      .tally_o    (tally[i+1])
    );
  end

  assign found       = seen[TABLE_ENTRIES];
  assign found_tally = tally[TABLE_ENTRIES];
  assign full        = occ_q == CntW'(TABLE_ENTRIES);
  assign pass        = (item_q.ip_protocol == ucsc_pkg::ProtoUdp) &&
                       (item_q.dest_port == listen_q);
  assign commit      = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    res.status       = ucsc_pkg::ST_DROPPED;
    res.packet_count = 32'd0;
    ctl              = '0;
    occ_d            = occ_q;
    if (pass) begin
      if (item_q.op == ucsc_pkg::OP_REMOVE) begin
        if (found) begin
          res.status = ucsc_pkg::ST_REMOVED;
          ctl.remove = commit;
          if (commit) occ_d = occ_q - CntW'(1);
        end else begin
          res.status = ucsc_pkg::ST_MISS;
        end
      end else if (found) begin
        res.status       = ucsc_pkg::ST_KNOWN;
        res.packet_count = ucsc_pkg::sat_inc(found_tally);
        ctl.bump         = commit;
      end else if (!full) begin
        res.status       = ucsc_pkg::ST_NEW;
        res.packet_count = 32'd1;
        ctl.insert       = commit;
        if (commit) occ_d = occ_q + CntW'(1);
      end else begin
        res.status = ucsc_pkg::ST_FULL;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_LOOKUP;
      S_LOOKUP: if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      listen_q    <= ucsc_pkg::ListenPortReset;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) listen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) item_q <= in_data_i;
    if (commit) out_q <= res;
  end

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(TABLE_ENTRIES))
    else $error("occupancy beyond table size");

  a_occ_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(occ_q))
    else $error("occupancy changed outside commit");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("committed result not presented");

  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && res.status == ucsc_pkg::ST_NEW) |=> occ_q == $past(occ_q) + CntW'(1))
    else $error("new session did not grow the table");
`endif

endmodule

### bench/udp_client_session_counter_table_top_tb.sv
// Testbench for the UDP client session counter table: queue-fed predicting driver, checking monitor.
module udp_client_session_counter_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyPool = 22;
  localparam int unsigned DrainLimit = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  ucsc_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  ucsc_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [15:0]         cfg_data_i = '0;

  logic        calm = 1'b0;
  int unsigned errors = 0;

  ucsc_pkg::in_item_t  datagram_queue[$];
  ucsc_pkg::out_item_t expected_outcomes[$];

  logic [15:0] listen_port_now = ucsc_pkg::ListenPortReset;
  logic [31:0] sess_addr [ucsc_pkg::TableEntries];
  logic [15:0] sess_port [ucsc_pkg::TableEntries];
  logic [31:0] sess_tally [ucsc_pkg::TableEntries];
  int unsigned sess_used = 0;

  logic [31:0] pool_ip [KeyPool];
  logic [15:0] pool_port [KeyPool];

  udp_client_session_counter_table_top dut (.*);

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("error at %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic ucsc_pkg::out_item_t tally_session(input ucsc_pkg::in_item_t it);
    ucsc_pkg::out_item_t res;
    int unsigned         hit;
    res.status = ucsc_pkg::ST_DROPPED;
    res.packet_count = '0;
    hit = ucsc_pkg::TableEntries;
    if (it.ip_protocol != ucsc_pkg::ProtoUdp || it.dest_port != listen_port_now) return res;
    for (int unsigned i = 0; i < sess_used; i++) begin
      if (hit == ucsc_pkg::TableEntries && sess_addr[i] == it.src_addr &&
          sess_port[i] == it.src_port)
        hit = i;
    end
    if (it.op == ucsc_pkg::OP_REMOVE) begin
      if (hit < ucsc_pkg::TableEntries) begin
        sess_addr[hit] = sess_addr[sess_used - 1];
        sess_port[hit] = sess_port[sess_used - 1];
        sess_tally[hit] = sess_tally[sess_used - 1];
        sess_used--;
        res.status = ucsc_pkg::ST_REMOVED;
      end else begin
        res.status = ucsc_pkg::ST_MISS;
      end
    end else if (hit < ucsc_pkg::TableEntries) begin
      if (sess_tally[hit] != '1) sess_tally[hit]++;
      res.status = ucsc_pkg::ST_KNOWN;
      res.packet_count = sess_tally[hit];
    end else if (sess_used < ucsc_pkg::TableEntries) begin
      sess_addr[sess_used] = it.src_addr;
      sess_port[sess_used] = it.src_port;
      sess_tally[sess_used] = 32'd1;
      sess_used++;
      res.status = ucsc_pkg::ST_NEW;
      res.packet_count = 32'd1;
    end else begin
      res.status = ucsc_pkg::ST_FULL;
    end
    return res;
  endfunction

  // driver: predict on each accepted beat, hold a stalled beat
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_outcomes.push_back(tally_session(in_data_i));
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (datagram_queue.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        in_valid_i <= 1'b1;
        in_data_i <= datagram_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    ucsc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_outcomes.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.packet_count !== want.packet_count)
          report_mismatch($sformatf("packet_count %0d, expected %0d",
                                    out_data_o.packet_count, want.packet_count));
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < 36);
  end

  task automatic push_item(input ucsc_pkg::op_e op, input logic [31:0] ip,
                           input logic [15:0] port, input logic [15:0] dport,
                           input logic [7:0] proto);
    ucsc_pkg::in_item_t it;
    it.op = op;
    it.src_addr = ip;
    it.src_port = port;
    it.dest_port = dport;
    it.ip_protocol = proto;
    datagram_queue.push_back(it);
  endtask

  task automatic drain_results();
    for (int unsigned n = 0; n < DrainLimit; n++) begin
      if (datagram_queue.size() == 0 && !in_valid_i && expected_outcomes.size() == 0) break;
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_listen_port(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    listen_port_now = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] lport, input int unsigned items,
                           input int unsigned remove_pct, input logic quiet);
    ucsc_pkg::in_item_t it;
    int unsigned        r;
    int unsigned        k;
    drain_results();
    write_listen_port(lport);
    calm <= quiet;
    repeat (items) begin
      r = $urandom_range(99);
      k = $urandom_range(KeyPool - 1);
      it.op = ($urandom_range(99) < remove_pct) ? ucsc_pkg::OP_REMOVE : ucsc_pkg::OP_DATAGRAM;
      it.src_addr = pool_ip[k];
      it.src_port = pool_port[k];
      it.dest_port = lport;
      it.ip_protocol = ucsc_pkg::ProtoUdp;
      if (r < 6) begin
        it.ip_protocol = 8'($urandom);
      end else if (r < 12) begin
        it.dest_port = 16'($urandom);
      end else if (r < 18) begin
        it.src_addr = $urandom;
        it.src_port = 16'($urandom);
      end
      datagram_queue.push_back(it);
    end
  endtask

  initial begin : stimulus
    for (int unsigned i = 0; i < KeyPool; i++) begin
      pool_ip[i] = $urandom;
      pool_port[i] = 16'($urandom);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(ucsc_pkg::OP_DATAGRAM, 32'h0, 16'h0, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_DATAGRAM, 32'h0, 16'h0, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_DATAGRAM, 32'hFFFF_FFFF, 16'hFFFF, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_DATAGRAM, 32'h0, 16'h0, ucsc_pkg::ListenPortReset, 8'hFF);
    push_item(ucsc_pkg::OP_DATAGRAM, 32'h0, 16'h0, 16'hFFFF, ucsc_pkg::ProtoUdp);
    // filtered remove leaves the session in place
    push_item(ucsc_pkg::OP_REMOVE, 32'h0, 16'h0, ucsc_pkg::ListenPortReset, 8'd6);
    push_item(ucsc_pkg::OP_REMOVE, 32'h1, 16'h1, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_REMOVE, 32'h0, 16'h0, ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);
    for (int unsigned i = 0; i < ucsc_pkg::TableEntries; i++)
      push_item(ucsc_pkg::OP_DATAGRAM, pool_ip[i], pool_port[i], ucsc_pkg::ListenPortReset,
                ucsc_pkg::ProtoUdp);
    push_item(ucsc_pkg::OP_DATAGRAM, pool_ip[ucsc_pkg::TableEntries],
              pool_port[ucsc_pkg::TableEntries], ucsc_pkg::ListenPortReset,
              ucsc_pkg::ProtoUdp);

    run_phase(16'h0000, 150, 35, 1'b0);
    run_phase(16'hFFFF, 150, 55, 1'b1);
    run_phase(16'($urandom), 150, 30, 1'b0);
    run_phase(ucsc_pkg::ListenPortReset, 150, 45, 1'b0);

    drain_results();
    if (expected_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(400_000 * 20);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
design/ucsc_pkg.sv
design/ucsc_cell.sv
design/udp_client_session_counter_table_top.sv
bench/udp_client_session_counter_table_top_tb.sv
